// ----- hdl/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg
// Shared widths, types and the CORDIC arctangent table of the Euler
// rotation matrix block.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int TURN_W         = 32;
    localparam int WORK_FRAC      = 30;
    localparam int CORDIC_STEPS   = 31;
    localparam int CW             = 34;
    localparam int Q_W            = 32;
    localparam int P_W            = 64;
    localparam int LANES          = 3;
    localparam int ENTRIES        = 9;
    localparam int CORDIC_K       = 652032874;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic signed [CW-1:0]         cw_t;
    typedef logic signed [Q_W-1:0]        q_t;
    typedef logic signed [P_W-1:0]        prod_t;

    typedef struct packed {
        q_t s;
        q_t c;
    } sc_t;

    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

    // atan(2^-i) in turn units, 2^32 per turn
    function automatic logic [TURN_W-1:0] atan_turn(input int unsigned i);
        logic [TURN_W-1:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/erm_angle_if.sv -----
// ----------------------------------------------------------------------------
// erm_angle_if
// Input channel: one item is an Euler angle triple.
// ----------------------------------------------------------------------------
interface erm_angle_if;
    import erm_pkg::*;

    logic   valid;
    logic   ready;
    angle_t angle_alpha;
    angle_t angle_beta;
    angle_t angle_gamma;

    modport source (output valid, output angle_alpha, output angle_beta,
                    output angle_gamma, input ready);
    modport sink   (input valid, input angle_alpha, input angle_beta,
                    input angle_gamma, output ready);
endinterface

// ----- hdl/erm_matrix_if.sv -----
// ----------------------------------------------------------------------------
// erm_matrix_if
// Output channel: one item is a 3x3 rotation matrix in Q1.14.
// ----------------------------------------------------------------------------
interface erm_matrix_if;
    import erm_pkg::*;

    logic  valid;
    logic  ready;
    coef_t m00, m01, m02;
    coef_t m10, m11, m12;
    coef_t m20, m21, m22;

    modport source (output valid, output m00, output m01, output m02,
                    output m10, output m11, output m12, output m20,
                    output m21, output m22, input ready);
    modport sink   (input valid, input m00, input m01, input m02,
                    input m10, input m11, input m12, input m20,
                    input m21, input m22, output ready);
endinterface

// ----- hdl/erm_sincos.sv -----
// ----------------------------------------------------------------------------
// erm_sincos
// Three-lane pipelined CORDIC: quadrant fold, one rotation per stage,
// then clamp and sign restore. Sine and cosine in Q30.
// ----------------------------------------------------------------------------
module erm_sincos (
    input  logic              clk,
    input  logic              rst_n,
    input  erm_pkg::pipe_ctl_t ctl,
    input  erm_pkg::angle_t   angle [erm_pkg::LANES],
    output logic              vld,
    output erm_pkg::sc_t      sc    [erm_pkg::LANES]
);
    import erm_pkg::*;

    localparam cw_t Q_ONE = cw_t'(64'sd1 <<< WORK_FRAC);

    logic vld_reg [CORDIC_STEPS+1];
    logic out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= CORDIC_STEPS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vld_reg[0] <= ctl.vld;
            for (int s = 0; s < CORDIC_STEPS; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
            out_vld_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    assign vld = out_vld_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        cw_t               x_reg    [CORDIC_STEPS+1];
        cw_t               y_reg    [CORDIC_STEPS+1];
        cw_t               z_reg    [CORDIC_STEPS];
        logic              flip_reg [CORDIC_STEPS+1];
        sc_t               sc_reg;
        logic [TURN_W-1:0] turn;
        logic              fold;
        logic [TURN_W-1:0] resid;
        cw_t               xc, yc;

        assign turn  = TURN_W'(unsigned'(angle[l])) << (TURN_W - ANGLE_BITS);
        assign fold  = turn[TURN_W-1] ^ turn[TURN_W-2];
        assign resid = {turn[TURN_W-1] ^ fold, turn[TURN_W-2:0]};

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                x_reg[0]    <= cw_t'(CORDIC_K);
                y_reg[0]    <= '0;
                z_reg[0]    <= CW'(signed'(resid));
                flip_reg[0] <= fold;
            end
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic dir;
            cw_t  dx, dy;

            assign dir = !z_reg[i][CW-1];
            assign dx  = y_reg[i] >>> i;
            assign dy  = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (ctl.adv)
                begin
                    x_reg[i+1]    <= dir ? x_reg[i] - dx : x_reg[i] + dx;
                    y_reg[i+1]    <= dir ? y_reg[i] + dy : y_reg[i] - dy;
                    flip_reg[i+1] <= flip_reg[i];
                end
            end

            if (i < CORDIC_STEPS - 1)
            begin : g_z
                cw_t at;

                assign at = CW'(atan_turn(i));

                always_ff @(posedge clk)
                begin
                    if (ctl.adv)
                    begin
                        z_reg[i+1] <= dir ? z_reg[i] - at : z_reg[i] + at;
                    end
                end
            end
        end

        always_comb
        begin
            xc = x_reg[CORDIC_STEPS];
            if (xc > Q_ONE)
            begin
                xc = Q_ONE;
            end
            else if (xc < -Q_ONE)
            begin
                xc = -Q_ONE;
            end
            yc = y_reg[CORDIC_STEPS];
            if (yc > Q_ONE)
            begin
                yc = Q_ONE;
            end
            else if (yc < -Q_ONE)
            begin
                yc = -Q_ONE;
            end
            if (flip_reg[CORDIC_STEPS])
            begin
                xc = -xc;
                yc = -yc;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                sc_reg.c <= Q_W'(xc);
                sc_reg.s <= Q_W'(yc);
            end
        end

        assign sc[l] = sc_reg;
    end

endmodule

// ----- hdl/erm_mat.sv -----
// ----------------------------------------------------------------------------
// erm_mat
// Matrix build: first products, Q30 rounding of sa*sb and ca*sb, second
// products, entry sums, then rounding and saturation to Q1.14.
// ----------------------------------------------------------------------------
module erm_mat (
    input  logic               clk,
    input  logic               rst_n,
    input  erm_pkg::pipe_ctl_t ctl,
    input  erm_pkg::sc_t       sc [erm_pkg::LANES],
    output logic               vld,
    output erm_pkg::coef_t     m  [erm_pkg::ENTRIES]
);
    import erm_pkg::*;

    localparam prod_t COEF_ONE = prod_t'(64'sd1 <<< COEF_FRAC_BITS);
    localparam prod_t HALF_Q   = prod_t'(64'sd1 <<< (WORK_FRAC - 1));

    function automatic coef_t to_coef(input prod_t v, input int unsigned sh);
        prod_t r;
        if (sh == 0)
        begin
            r = v;
        end
        else
        begin
            r = (v + (prod_t'(1) <<< (sh - 1))) >>> sh;
        end
        if (r > COEF_ONE)
        begin
            r = COEF_ONE;
        end
        else if (r < -COEF_ONE)
        begin
            r = -COEF_ONE;
        end
        return COEF_W'(r);
    endfunction

    q_t sa, ca, sb, cb, sg, cg;
    assign sa = sc[0].s;
    assign ca = sc[0].c;
    assign sb = sc[1].s;
    assign cb = sc[1].c;
    assign sg = sc[2].s;
    assign cg = sc[2].c;

    logic  vld_reg [4];
    // stage 1
    prod_t cbcg1_reg, cbsg1_reg, sacb1_reg, cacb1_reg;
    prod_t casg1_reg, cacg1_reg, sasg1_reg, sacg1_reg, sasb1_reg, casb1_reg;
    prod_t nsb1_reg;
    q_t    cg1_reg, sg1_reg;
    // stage 2
    prod_t cbcg2_reg, cbsg2_reg, sacb2_reg, cacb2_reg;
    prod_t casg2_reg, cacg2_reg, sasg2_reg, sacg2_reg, nsb2_reg;
    q_t    sasb2_reg, casb2_reg, cg2_reg, sg2_reg;
    // stage 3
    prod_t cbcg3_reg, cbsg3_reg, sacb3_reg, cacb3_reg;
    prod_t casg3_reg, cacg3_reg, sasg3_reg, sacg3_reg, nsb3_reg;
    prod_t sbcg3_reg, sbsg3_reg, cbcg_c3_reg, cbsg_c3_reg;
    // stage 4
    prod_t sum_reg [ENTRIES];
    // stage 5
    coef_t m_reg   [ENTRIES];
    logic  out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 4; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vld_reg[0]  <= ctl.vld;
            vld_reg[1]  <= vld_reg[0];
            vld_reg[2]  <= vld_reg[1];
            vld_reg[3]  <= vld_reg[2];
            out_vld_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            cbcg1_reg <= P_W'(cb) * P_W'(cg);
            cbsg1_reg <= P_W'(cb) * P_W'(sg);
            sacb1_reg <= P_W'(sa) * P_W'(cb);
            cacb1_reg <= P_W'(ca) * P_W'(cb);
            casg1_reg <= P_W'(ca) * P_W'(sg);
            cacg1_reg <= P_W'(ca) * P_W'(cg);
            sasg1_reg <= P_W'(sa) * P_W'(sg);
            sacg1_reg <= P_W'(sa) * P_W'(cg);
            sasb1_reg <= P_W'(sa) * P_W'(sb);
            casb1_reg <= P_W'(ca) * P_W'(sb);
            nsb1_reg  <= -P_W'(sb);
            cg1_reg   <= cg;
            sg1_reg   <= sg;

            cbcg2_reg <= cbcg1_reg;
            cbsg2_reg <= cbsg1_reg;
            sacb2_reg <= sacb1_reg;
            cacb2_reg <= cacb1_reg;
            casg2_reg <= casg1_reg;
            cacg2_reg <= cacg1_reg;
            sasg2_reg <= sasg1_reg;
            sacg2_reg <= sacg1_reg;
            nsb2_reg  <= nsb1_reg;
            sasb2_reg <= Q_W'((sasb1_reg + HALF_Q) >>> WORK_FRAC);
            casb2_reg <= Q_W'((casb1_reg + HALF_Q) >>> WORK_FRAC);
            cg2_reg   <= cg1_reg;
            sg2_reg   <= sg1_reg;

            cbcg3_reg   <= cbcg2_reg;
            cbsg3_reg   <= cbsg2_reg;
            sacb3_reg   <= sacb2_reg;
            cacb3_reg   <= cacb2_reg;
            casg3_reg   <= casg2_reg;
            cacg3_reg   <= cacg2_reg;
            sasg3_reg   <= sasg2_reg;
            sacg3_reg   <= sacg2_reg;
            nsb3_reg    <= nsb2_reg;
            sbcg3_reg   <= P_W'(sasb2_reg) * P_W'(cg2_reg);
            sbsg3_reg   <= P_W'(sasb2_reg) * P_W'(sg2_reg);
            cbcg_c3_reg <= P_W'(casb2_reg) * P_W'(cg2_reg);
            cbsg_c3_reg <= P_W'(casb2_reg) * P_W'(sg2_reg);

            sum_reg[0] <= cbcg3_reg;
            sum_reg[1] <= cbsg3_reg;
            sum_reg[2] <= nsb3_reg;
            sum_reg[3] <= sbcg3_reg - casg3_reg;
            sum_reg[4] <= sbsg3_reg + cacg3_reg;
            sum_reg[5] <= sacb3_reg;
            sum_reg[6] <= cbcg_c3_reg + sasg3_reg;
            sum_reg[7] <= cbsg_c3_reg - sacg3_reg;
            sum_reg[8] <= cacb3_reg;

            for (int e = 0; e < ENTRIES; e++)
            begin
                if (e == 2)
                begin
                    m_reg[e] <= to_coef(sum_reg[e], WORK_FRAC - COEF_FRAC_BITS);
                end
                else
                begin
                    m_reg[e] <= to_coef(sum_reg[e], 2 * WORK_FRAC - COEF_FRAC_BITS);
                end
            end
        end
    end

    assign vld = out_vld_reg;
    assign m   = m_reg;

endmodule

// ----- hdl/euler_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// Euler angles to 3x3 rotation matrix, Q1.14, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  angles   | in  | angle_alpha, angle_beta, angle_gamma (16b binary angle)
//  matrix   | out | m00..m22 (16b signed Q1.14)
//
//  One item per cycle while the output is not stalled; 33 CORDIC stages,
//  5 product and rounding stages, 1 output register.
//  Reset clears the valid bits only; the pipeline accepts at once.
//  A stalled output freezes every stage; angles.ready drops in that cycle.
// ----------------------------------------------------------------------------
module euler_rotation_matrix (
    input  logic          clk,
    input  logic          rst_n,
    erm_angle_if.sink     angles,
    erm_matrix_if.source  matrix
);
    import erm_pkg::*;

    logic      adv;
    pipe_ctl_t sc_ctl, mat_ctl;
    angle_t    ang    [LANES];
    sc_t       sc     [LANES];
    logic      sc_vld, mat_vld;
    coef_t     m      [ENTRIES];
    coef_t     m_reg  [ENTRIES];
    logic      out_vld_reg;

    assign adv          = !out_vld_reg || matrix.ready;
    assign angles.ready = adv;

    assign ang[0] = angles.angle_alpha;
    assign ang[1] = angles.angle_beta;
    assign ang[2] = angles.angle_gamma;

    assign sc_ctl  = '{adv: adv, vld: angles.valid};
    assign mat_ctl = '{adv: adv, vld: sc_vld};

    erm_sincos u_sincos (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sc_ctl),
        .angle (ang),
        .vld   (sc_vld),
        .sc    (sc)
    );

    erm_mat u_mat (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mat_ctl),
        .sc    (sc),
        .vld   (mat_vld),
        .m     (m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= mat_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= m;
        end
    end

    assign matrix.valid = out_vld_reg;
    assign matrix.m00   = m_reg[0];
    assign matrix.m01   = m_reg[1];
    assign matrix.m02   = m_reg[2];
    assign matrix.m10   = m_reg[3];
    assign matrix.m11   = m_reg[4];
    assign matrix.m12   = m_reg[5];
    assign matrix.m20   = m_reg[6];
    assign matrix.m21   = m_reg[7];
    assign matrix.m22   = m_reg[8];

endmodule

// ----- hdl/erm_checker.sv -----
// ----------------------------------------------------------------------------
// erm_checker
// Port-level checks of the rotation matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module erm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input erm_pkg::coef_t m00,
    input erm_pkg::coef_t m02,
    input erm_pkg::coef_t m22
);
    import erm_pkg::*;

    localparam coef_t ONE = coef_t'(1 <<< COEF_FRAC_BITS);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m22))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output side");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m00 <= ONE) && (m00 >= -ONE) && (m22 <= ONE) && (m22 >= -ONE))
        else $error("diagonal entry out of range");

    a_m02: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m02 <= ONE) && (m02 >= -ONE))
        else $error("m02 out of range");

    a_noin: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && $past(!out_valid) && !out_valid |-> in_ready)
        else $error("ready low with empty output");

endmodule

bind euler_rotation_matrix erm_checker u_erm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (angles.valid),
    .in_ready  (angles.ready),
    .out_valid (matrix.valid),
    .out_ready (matrix.ready),
    .m00       (matrix.m00),
    .m02       (matrix.m02),
    .m22       (matrix.m22)
);

// ----- dv/erm_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// erm_tb_if
// Testbench types: the block's channels are used as they come from the
// RTL; this file holds the packed matrix item for the scoreboard.
// ----------------------------------------------------------------------------
package erm_tb_pkg;
    import erm_pkg::*;

    typedef struct packed {
        coef_t m00, m01, m02;
        coef_t m10, m11, m12;
        coef_t m20, m21, m22;
    } mat9_t;
endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives angle triples into the Euler rotation matrix block with bursty
// input and a stalling output, predicts each matrix with a bit-exact
// CORDIC and product model, and checks every entry in order.
// ----------------------------------------------------------------------------
module tb_top;
    import erm_pkg::*;
    import erm_tb_pkg::*;

    class matrix_board;
        mat9_t   pending[$];
        int      errors;

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint round_to(longint v, int s);
            if (s == 0)
                return v;
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        static function longint sat(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        static function void sin_cos(angle_t a, output longint s, output longint c);
            logic [31:0] t;
            bit          flip;
            longint      x, y, z, nx;
            t = {a, {(32 - ANGLE_BITS){1'b0}}};
            flip = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
            if (flip)
                t = t - 32'h80000000;
            z = longint'($signed(t));
            x = CORDIC_K;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - floor_shift(y, i);
                    y = y + floor_shift(x, i);
                    z = z - longint'(atan_turn(i));
                end
                else
                begin
                    nx = x + floor_shift(y, i);
                    y = y - floor_shift(x, i);
                    z = z + longint'(atan_turn(i));
                end
                x = nx;
            end
            x = sat(x, 64'sd1 <<< WORK_FRAC);
            y = sat(y, 64'sd1 <<< WORK_FRAC);
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            s = y;
            c = x;
        endfunction

        static function coef_t to_coef(longint v, int frac);
            return coef_t'(sat(round_to(v, frac - COEF_FRAC_BITS),
                               64'sd1 <<< COEF_FRAC_BITS));
        endfunction

        function void note_angles(angle_t a, angle_t b, angle_t g);
            longint  sa, ca, sb, cb, sg, cg, sasb, casb;
            mat9_t   m;
            sin_cos(a, sa, ca);
            sin_cos(b, sb, cb);
            sin_cos(g, sg, cg);
            sasb = round_to(sa * sb, WORK_FRAC);
            casb = round_to(ca * sb, WORK_FRAC);
            m.m00 = to_coef(cb * cg, 2 * WORK_FRAC);
            m.m01 = to_coef(cb * sg, 2 * WORK_FRAC);
            m.m02 = to_coef(-sb, WORK_FRAC);
            m.m10 = to_coef(sasb * cg - ca * sg, 2 * WORK_FRAC);
            m.m11 = to_coef(sasb * sg + ca * cg, 2 * WORK_FRAC);
            m.m12 = to_coef(sa * cb, 2 * WORK_FRAC);
            m.m20 = to_coef(casb * cg + sa * sg, 2 * WORK_FRAC);
            m.m21 = to_coef(casb * sg - sa * cg, 2 * WORK_FRAC);
            m.m22 = to_coef(ca * cb, 2 * WORK_FRAC);
            pending.push_back(m);
        endfunction

        function void cmp(string name, coef_t e, coef_t a);
            if (e !== a)
            begin
                $error("%s expected %0d actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_matrix(mat9_t a);
            mat9_t e;
            if (pending.size() == 0)
            begin
                $error("matrix with no angles pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("m00", e.m00, a.m00);
            cmp("m01", e.m01, a.m01);
            cmp("m02", e.m02, a.m02);
            cmp("m10", e.m10, a.m10);
            cmp("m11", e.m11, a.m11);
            cmp("m12", e.m12, a.m12);
            cmp("m20", e.m20, a.m20);
            cmp("m21", e.m21, a.m21);
            cmp("m22", e.m22, a.m22);
        endfunction
    endclass

    localparam int LATENCY = 39;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   hold_off = 1'b0;
    matrix_board board = new();

    erm_angle_if  angles();
    erm_matrix_if matrix();

    euler_rotation_matrix u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles),
        .matrix (matrix)
    );

    always #10 clk = ~clk;

    initial
    begin
        angles.valid = 1'b0;
        angles.angle_alpha = '0;
        angles.angle_beta = '0;
        angles.angle_gamma = '0;
        matrix.ready = 1'b0;
    end

    always @(posedge clk)
        if (rst_n && matrix.valid && matrix.ready)
            board.check_matrix({matrix.m00, matrix.m01, matrix.m02,
                                matrix.m10, matrix.m11, matrix.m12,
                                matrix.m20, matrix.m21, matrix.m22});

    // receiver stall pattern
    initial
    begin
        int phase;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_off)
                matrix.ready <= 1'b0;
            else if ((phase / 300) % 3 == 0)
                matrix.ready <= 1'b1;
            else
                matrix.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic angle_t pick_angle();
        case ($urandom_range(0, 9))
            0:       return angle_t'(16'h8000);
            1:       return angle_t'(16'h7fff);
            2:       return angle_t'({2'($urandom_range(0, 3)), 14'h0});
            3:       return angle_t'({2'($urandom_range(0, 3)), 13'h0, 1'b1}
                                     + 16'($urandom_range(0, 4)) - 16'd2);
            default: return angle_t'($urandom);
        endcase
    endfunction

    task automatic send_angles(angle_t a, angle_t b, angle_t g);
        angles.valid <= 1'b1;
        angles.angle_alpha <= a;
        angles.angle_beta <= b;
        angles.angle_gamma <= g;
        @(posedge clk);
        while (!angles.ready)
            @(posedge clk);
        board.note_angles(a, b, g);
        @(negedge clk);
    endtask

    task automatic idle_input(int n);
        angles.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        angles.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        angle_t corner[8];
        int     sent, burst;
        bit     held, drained;
        corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000,
                   16'shc000, 16'sh2000, 16'sh0001, 16'shffff};
        held = 1'b0;
        drained = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < 8; i++)
            send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
        for (int i = 0; i < 8; i++)
            send_angles(corner[i], corner[i], corner[i]);
        send_angles(16'sh5555, 16'shaaaa, 16'sh1234);
        drain();
        sent = 0;
        while (sent < 1100)
        begin
            if (!held && sent >= 300)
            begin
                held = 1'b1;
                hold_off = 1'b1;
                fork
                    begin
                        repeat (150) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (!drained && sent >= 700)
            begin
                drained = 1'b1;
                drain();
            end
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                send_angles(pick_angle(), pick_angle(), pick_angle());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_input($urandom_range(1, 12));
        end
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
